// ===== hw/rtl/bfam_pkg.sv =====
// Shared types, constants and helpers for the breath force alarm monitor.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package bfam_pkg;

   // Bar graph steps and fraction bits of the gram scale
   localparam int BAR_STEPS = 5;
   localparam int FRAC_BITS = 4;

   // Field widths
   localparam int SAMPLE_W  = 20;
   localparam int AVG_W     = 16;
   localparam int BASE_W    = 8;
   localparam int STEP_W    = 4;
   localparam int TIME_W    = 32;
   localparam int BAR_W     = 5;
   localparam int MARGIN_W  = 8;
   localparam int PERIOD_W  = 16;
   localparam int ALPHA_W   = 3;

   // Signed width for threshold compares: whole grams fit 13 bits signed
   localparam int CMP_W = (13 + FRAC_BITS > AVG_W + 1) ? 13 + FRAC_BITS : AVG_W + 1;

   // Beat widths on the stream ports
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_ALPHA_SHIFT    = 3'd0,
      CSR_TOGGLE_PERIOD  = 3'd1,
      CSR_HEART_PERIOD   = 3'd2,
      CSR_MUTE_LENGTH    = 3'd3,
      CSR_PRESS_WINDOW   = 3'd4,
      CSR_UPPER_MARGIN   = 3'd5,
      CSR_LOWER_MARGIN   = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 3'd2;
   localparam logic [PERIOD_W-1:0] TOGGLE_RST = 16'd100;
   localparam logic [PERIOD_W-1:0] HEART_RST  = 16'd8000;
   localparam logic [PERIOD_W-1:0] MUTE_RST   = 16'd30000;
   localparam logic [PERIOD_W-1:0] PRESS_RST  = 16'd1500;
   localparam logic [MARGIN_W-1:0] UPPER_RST  = 8'd20;
   localparam logic [MARGIN_W-1:0] LOWER_RST  = 8'd5;

   // Press count that opens the mute window
   localparam logic [1:0] PRESS_MUTE_COUNT = 2'd3;
   // Ready band width and lower alarm floor, whole grams
   localparam int READY_BAND_GRAMS = 3;
   localparam int ALARM_FLOOR_GRAMS = 2;

   typedef struct packed {
      logic [ALPHA_W-1:0]  alpha_shift;
      logic [PERIOD_W-1:0] toggle_period_ms;
      logic [PERIOD_W-1:0] heartbeat_period_ms;
      logic [PERIOD_W-1:0] mute_length_ms;
      logic [PERIOD_W-1:0] press_window_ms;
      logic [MARGIN_W-1:0] upper_margin_grams;
      logic [MARGIN_W-1:0] lower_margin_grams;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_q4;
      logic [BASE_W-1:0]          base_grams;
      logic [STEP_W-1:0]          step_grams;
      logic [TIME_W-1:0]          now_ms;
      logic                       running;
      logic                       start_press;
   } item_type;

   typedef struct packed {
      logic [AVG_W-1:0] filtered_q4;
      logic [BAR_W-1:0] bar_leds;
      logic             ready_lamp;
      logic             alarm;
      logic             buzzer_level;
      logic             chirp;
      logic             muted;
   } result_type;

   // True when later lies strictly after earlier on the wrapping time line
   function automatic logic positive_gap(input logic [TIME_W-1:0] later,
                                         input logic [TIME_W-1:0] earlier);
      logic [TIME_W-1:0] d;
      d = later - earlier;
      return (d != '0) && !d[TIME_W-1];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfam_csr.sv =====
// Configuration register file with an APB-style port.
// Depends on bfam_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module bfam_csr
   import bfam_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Decode the write; addresses past the last register are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_ALPHA_SHIFT:   cfg_in.alpha_shift         = csr_pwdata[ALPHA_W-1:0];
            CSR_TOGGLE_PERIOD: cfg_in.toggle_period_ms    = csr_pwdata[PERIOD_W-1:0];
            CSR_HEART_PERIOD:  cfg_in.heartbeat_period_ms = csr_pwdata[PERIOD_W-1:0];
            CSR_MUTE_LENGTH:   cfg_in.mute_length_ms      = csr_pwdata[PERIOD_W-1:0];
            CSR_PRESS_WINDOW:  cfg_in.press_window_ms     = csr_pwdata[PERIOD_W-1:0];
            CSR_UPPER_MARGIN:  cfg_in.upper_margin_grams  = csr_pwdata[MARGIN_W-1:0];
            CSR_LOWER_MARGIN:  cfg_in.lower_margin_grams  = csr_pwdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_shift         <= ALPHA_RST;
         cfg_ff.toggle_period_ms    <= TOGGLE_RST;
         cfg_ff.heartbeat_period_ms <= HEART_RST;
         cfg_ff.mute_length_ms      <= MUTE_RST;
         cfg_ff.press_window_ms     <= PRESS_RST;
         cfg_ff.upper_margin_grams  <= UPPER_RST;
         cfg_ff.lower_margin_grams  <= LOWER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (index)
         CSR_ALPHA_SHIFT:   csr_prdata = CSR_DATA_W'(cfg_ff.alpha_shift);
         CSR_TOGGLE_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.toggle_period_ms);
         CSR_HEART_PERIOD:  csr_prdata = CSR_DATA_W'(cfg_ff.heartbeat_period_ms);
         CSR_MUTE_LENGTH:   csr_prdata = CSR_DATA_W'(cfg_ff.mute_length_ms);
         CSR_PRESS_WINDOW:  csr_prdata = CSR_DATA_W'(cfg_ff.press_window_ms);
         CSR_UPPER_MARGIN:  csr_prdata = CSR_DATA_W'(cfg_ff.upper_margin_grams);
         CSR_LOWER_MARGIN:  csr_prdata = CSR_DATA_W'(cfg_ff.lower_margin_grams);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bfam_core.sv =====
// Per-sample logic and state: press counter, mute window, average filter,
// thresholds, bar graph, ready lamp, buzzer and heartbeat. Depends on bfam_pkg.
`default_nettype none

module bfam_core
   import bfam_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   // State
   logic [AVG_W-1:0]  avg_ff,         avg_in;
   logic              buzzer_ff,      buzzer_in;
   logic [TIME_W-1:0] last_toggle_ff, last_toggle_in;
   logic [TIME_W-1:0] last_chirp_ff,  last_chirp_in;
   logic [TIME_W-1:0] mute_end_ff,    mute_end_in;
   logic [1:0]        press_cnt_ff,   press_cnt_in;
   logic [TIME_W-1:0] last_press_ff,  last_press_in;

   logic [AVG_W-1:0]         x_clamped;
   logic signed [AVG_W:0]    diff;
   logic signed [AVG_W:0]    diff_sh;
   logic [AVG_W-1:0]         avg_new;
   logic [1:0]               press_cnt_next;
   logic signed [CMP_W-1:0]  f_s, base_s, step_s, upper_s, lower_s;
   logic signed [CMP_W-1:0]  ready_lo_s, base_lim_s, floor_s;
   logic                     in_alarm;
   logic [BAR_W-1:0]         bars;

   // Clamp the sample: negatives to zero, saturate above the average range
   always_comb begin
      if (item.sample_q4[SAMPLE_W-1])
         x_clamped = '0;
      else if (item.sample_q4[SAMPLE_W-2:AVG_W] != '0)
         x_clamped = '1;
      else
         x_clamped = item.sample_q4[AVG_W-1:0];
   end

   // Exponential average; arithmetic shift rounds toward minus infinity
   assign diff    = $signed({1'b0, x_clamped}) - $signed({1'b0, avg_ff});
   assign diff_sh = diff >>> cfg.alpha_shift;
   assign avg_new = avg_ff + diff_sh[AVG_W-1:0];

   // Thresholds in gram units scaled to the fixed-point average
   assign f_s        = $signed({{(CMP_W-AVG_W){1'b0}}, avg_new});
   assign base_s     = $signed({{(CMP_W-BASE_W){1'b0}}, item.base_grams});
   assign step_s     = $signed({{(CMP_W-STEP_W){1'b0}}, item.step_grams});
   assign upper_s    = (base_s + step_s * CMP_W'(BAR_STEPS)
                        + $signed({{(CMP_W-MARGIN_W){1'b0}}, cfg.upper_margin_grams}))
                       <<< FRAC_BITS;
   assign lower_s    = (base_s
                        - $signed({{(CMP_W-MARGIN_W){1'b0}}, cfg.lower_margin_grams}))
                       <<< FRAC_BITS;
   assign ready_lo_s = (base_s - CMP_W'(READY_BAND_GRAMS)) <<< FRAC_BITS;
   assign base_lim_s = base_s <<< FRAC_BITS;
   assign floor_s    = CMP_W'(ALARM_FLOOR_GRAMS) <<< FRAC_BITS;

   assign in_alarm = (f_s > upper_s) || ((f_s < lower_s) && (f_s > floor_s));

   // Bar graph: one compare per step; steps past the field width drop out
   always_comb begin
      bars = '0;
      for (int i = 0; i < BAR_W; i++) begin
         if (i < BAR_STEPS)
            bars[i] = f_s >= ((base_s + step_s * CMP_W'(i)) <<< FRAC_BITS);
      end
   end

   // Next state and result
   always_comb begin
      avg_in         = avg_ff;
      buzzer_in      = buzzer_ff;
      last_toggle_in = last_toggle_ff;
      last_chirp_in  = last_chirp_ff;
      mute_end_in    = mute_end_ff;
      press_cnt_in   = press_cnt_ff;
      last_press_in  = last_press_ff;
      press_cnt_next = press_cnt_ff;
      result         = '0;

      // Count presses; a third one in sequence opens the mute window
      if (item.start_press) begin
         if ((item.now_ms - last_press_ff) < TIME_W'(cfg.press_window_ms))
            press_cnt_next = press_cnt_ff + 2'd1;
         else
            press_cnt_next = 2'd1;
         last_press_in = item.now_ms;
         if (press_cnt_next == PRESS_MUTE_COUNT) begin
            mute_end_in  = item.now_ms + TIME_W'(cfg.mute_length_ms);
            press_cnt_in = '0;
         end else begin
            press_cnt_in = press_cnt_next;
         end
      end

      if (item.running) begin
         avg_in = avg_new;
         if (in_alarm) begin
            result.alarm = 1'b1;
            if ((item.now_ms - last_toggle_ff) > TIME_W'(cfg.toggle_period_ms)) begin
               buzzer_in      = !buzzer_ff;
               last_toggle_in = item.now_ms;
            end
         end else begin
            buzzer_in = 1'b0;
            if (positive_gap(item.now_ms, mute_end_in) &&
                (item.now_ms - last_chirp_ff) > TIME_W'(cfg.heartbeat_period_ms)) begin
               result.chirp  = 1'b1;
               last_chirp_in = item.now_ms;
            end
         end
         result.ready_lamp = (f_s >= ready_lo_s) && (f_s < base_lim_s);
         result.bar_leds   = bars;
      end else begin
         buzzer_in = 1'b0;
      end

      result.filtered_q4  = avg_in;
      result.buzzer_level = buzzer_in;
      result.muted        = positive_gap(mute_end_in, item.now_ms);
   end

   // Commit state on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff         <= '0;
         buzzer_ff      <= 1'b0;
         last_toggle_ff <= '0;
         last_chirp_ff  <= '0;
         mute_end_ff    <= '0;
         press_cnt_ff   <= '0;
         last_press_ff  <= '0;
      end else if (fire) begin
         avg_ff         <= avg_in;
         buzzer_ff      <= buzzer_in;
         last_toggle_ff <= last_toggle_in;
         last_chirp_ff  <= last_chirp_in;
         mute_end_ff    <= mute_end_in;
         press_cnt_ff   <= press_cnt_in;
         last_press_ff  <= last_press_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/breath_force_alarm_monitor_top.sv =====
// A request beat is held in the input register until the result register is free or
// draining, then is processed into the result register. Throughput: one beat per
// cycle while the result side does not stall; the input register refills while the
// result register drains, so a stalled result side holds two beats inside. The filter
// and alarm logic between the two registers bounds the clock. Reset (synchronous)
// empties both registers, zeroes the state and loads the register reset values.
`default_nettype none

module breath_force_alarm_monitor_top
   import bfam_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [19:0] sample_q4, [27:20] base_grams, [31:28] step_grams, [63:32] now_ms
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] running, [1] start_press
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   // Result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] filtered_q4, [20:16] bar_leds, [21] ready_lamp, [22] alarm,
   // [23] buzzer_level, [24] chirp, [25] muted, [31:26] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type core_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   bfam_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Process the held beat whenever the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.sample_q4   <= $signed(req_tdata[19:0]);
         item_ff.base_grams  <= req_tdata[27:20];
         item_ff.step_grams  <= req_tdata[31:28];
         item_ff.now_ms      <= req_tdata[63:32];
         item_ff.running     <= req_tuser[0];
         item_ff.start_press <= req_tuser[1];
      end
   end

   bfam_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.muted, rsp_ff.chirp, rsp_ff.buzzer_level,
                        rsp_ff.alarm, rsp_ff.ready_lamp, rsp_ff.bar_leds,
                        rsp_ff.filtered_q4};

   // A held beat that cannot advance stays held
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input beat dropped while result side stalled");

   // A processed beat always shows up on the result side
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat did not reach the result register");

   // Back-pressure only when the input register is full
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("request side stalled without cause");

   // Alarm and heartbeat chirp are mutually exclusive
   a_alarm_no_chirp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.alarm && rsp_ff.chirp))
      else $error("chirp given during alarm");

   // Buzzer only sounds on an alarm beat
   a_buzzer_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.buzzer_level |-> rsp_ff.alarm)
      else $error("buzzer on without alarm");

endmodule

`default_nettype wire
